### hdl/perbr_pkg.sv
package perbr_pkg;

  // Result status codes reported with every input word.
  typedef enum logic [2:0] {
    ST_HEADER    = 3'd0,
    ST_SKIP      = 3'd1,
    ST_FIXUP     = 3'd2,
    ST_ZERO_END  = 3'd3,
    ST_BAD_TYPE  = 3'd4,
    ST_MALFORMED = 3'd5,
    ST_IGNORED   = 3'd6
  } status_t;

  // Patch width codes.
  typedef enum logic [1:0] {
    FW_16 = 2'd0,
    FW_32 = 2'd1,
    FW_64 = 2'd2
  } width_t;

  // Relocation entry types that the engine understands.
  localparam logic [3:0] RT_ABSOLUTE = 4'd0;
  localparam logic [3:0] RT_HIGH     = 4'd1;
  localparam logic [3:0] RT_LOW      = 4'd2;
  localparam logic [3:0] RT_HIGHLOW  = 4'd3;
  localparam logic [3:0] RT_DIR64    = 4'd10;

  // Configuration register indexes.
  localparam logic CFG_IMAGE_DELTA = 1'b0;
  localparam logic CFG_DIR_BYTES   = 1'b1;

  // Size of a block header in bytes.
  localparam logic [31:0] HEADER_BYTES = 32'd8;

  // One result item.
  typedef struct packed {
    status_t     status;
    logic [32:0] fixup_address;
    width_t      fixup_width;
    logic [63:0] addend;
    logic        directory_done;
  } res_t;

endpackage

### hdl/perbr_parse.sv
module perbr_parse
  import perbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [15:0] word,
  input  logic        first,
  input  logic [63:0] image_delta,
  input  logic [31:0] directory_bytes,
  output res_t        res
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_H0,
    PH_H1,
    PH_H2,
    PH_H3,
    PH_ENTRY
  } phase_t;

  phase_t      phase;
  phase_t      phase_next;
  logic [31:0] page_address;
  logic [31:0] page_address_next;
  logic [15:0] header_low_half;
  logic [15:0] header_low_half_next;
  logic [30:0] entries_left;
  logic [30:0] entries_left_next;
  logic [32:0] bytes_consumed;
  logic [32:0] bytes_consumed_next;

  phase_t      phase_cur;
  logic [30:0] entries_cur;
  logic [32:0] bytes_cur;
  logic [33:0] bytes_sum;
  logic [32:0] bytes_add;
  logic        dir_end;
  logic [31:0] block_size;
  logic [31:0] size_body;
  logic [3:0]  entry_type;
  logic [11:0] entry_offset;
  logic [30:0] entries_dec;

  // A first word restarts the parse before the word itself is decoded.
  always_comb begin
    if (first) begin
      phase_cur   = (directory_bytes == 32'd0) ? PH_IDLE : PH_H0;
      entries_cur = '0;
      bytes_cur   = '0;
    end else begin
      phase_cur   = phase;
      entries_cur = entries_left;
      bytes_cur   = bytes_consumed;
    end
  end

  // Byte count with saturation, and the end-of-directory test at a block boundary.
  assign bytes_sum    = {1'b0, bytes_cur} + 34'd2;
  assign bytes_add    = bytes_sum[33] ? '1 : bytes_sum[32:0];
  assign dir_end      = bytes_add >= {1'b0, directory_bytes};
  assign block_size   = {word, header_low_half};
  assign size_body    = block_size - HEADER_BYTES;
  assign entry_type   = word[15:12];
  assign entry_offset = word[11:0];
  assign entries_dec  = entries_cur - 31'd1;

  // Decode of the current word and the next parser state.
  always_comb begin
    phase_next           = phase_cur;
    page_address_next    = page_address;
    header_low_half_next = header_low_half;
    entries_left_next    = entries_cur;
    bytes_consumed_next  = bytes_cur;
    res                  = '0;
    res.status           = ST_IGNORED;
    res.fixup_width      = FW_16;
    case (phase_cur)
      PH_H0: begin
        header_low_half_next = word;
        bytes_consumed_next  = bytes_add;
        res.status           = ST_HEADER;
        phase_next           = PH_H1;
      end
      PH_H1: begin
        page_address_next   = {word, header_low_half};
        bytes_consumed_next = bytes_add;
        res.status          = ST_HEADER;
        phase_next          = PH_H2;
      end
      PH_H2: begin
        header_low_half_next = word;
        bytes_consumed_next  = bytes_add;
        res.status           = ST_HEADER;
        phase_next           = PH_H3;
      end
      PH_H3: begin
        bytes_consumed_next = bytes_add;
        if (block_size == 32'd0) begin
          res.status         = ST_ZERO_END;
          res.directory_done = 1'b1;
          phase_next         = PH_IDLE;
        end else if (block_size < HEADER_BYTES) begin
          res.status = ST_MALFORMED;
          phase_next = PH_IDLE;
        end else begin
          res.status        = ST_HEADER;
          entries_left_next = size_body[31:1];
          if (size_body[31:1] == 31'd0) begin
            res.directory_done = dir_end;
            phase_next         = dir_end ? PH_IDLE : PH_H0;
          end else begin
            phase_next = PH_ENTRY;
          end
        end
      end
      PH_ENTRY: begin
        bytes_consumed_next = bytes_add;
        if (entry_type == RT_ABSOLUTE || entry_type == RT_HIGH || entry_type == RT_LOW ||
            entry_type == RT_HIGHLOW || entry_type == RT_DIR64) begin
          if (entry_type == RT_ABSOLUTE) begin
            res.status = ST_SKIP;
          end else begin
            res.status        = ST_FIXUP;
            res.fixup_address = {1'b0, page_address} + {21'd0, entry_offset};
          end
          case (entry_type)
            RT_HIGH: begin
              res.fixup_width = FW_16;
              res.addend      = {48'd0, image_delta[31:16]};
            end
            RT_LOW: begin
              res.fixup_width = FW_16;
              res.addend      = {48'd0, image_delta[15:0]};
            end
            RT_HIGHLOW: begin
              res.fixup_width = FW_32;
              res.addend      = {32'd0, image_delta[31:0]};
            end
            RT_DIR64: begin
              res.fixup_width = FW_64;
              res.addend      = image_delta;
            end
            default: begin
              res.fixup_width = FW_16;
              res.addend      = '0;
            end
          endcase
          entries_left_next = entries_dec;
          if (entries_dec == 31'd0) begin
            res.directory_done = dir_end;
            phase_next         = dir_end ? PH_IDLE : PH_H0;
          end
        end else begin
          res.status        = ST_BAD_TYPE;
          phase_next        = PH_IDLE;
          entries_left_next = '0;
        end
      end
      default: begin
        res.status = ST_IGNORED;
      end
    endcase
  end

  // Parser state advances once per accepted word.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      page_address    <= '0;
      header_low_half <= '0;
      entries_left    <= '0;
      bytes_consumed  <= '0;
    end else if (accept) begin
      phase           <= phase_next;
      page_address    <= page_address_next;
      header_low_half <= header_low_half_next;
      entries_left    <= entries_left_next;
      bytes_consumed  <= bytes_consumed_next;
    end
  end

endmodule

### hdl/perbr_out_reg.sv
module perbr_out_reg
  import perbr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  res_t res_in,
  input  logic out_ready,
  output logic out_valid,
  output res_t res_out
);

  // Result register: loads on every accepted word, empties when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_out <= res_in;
    end
  end

endmodule

### hdl/pe_base_relocation_engine_core.sv
// PE/COFF base relocation engine.
// Input channel (in_valid/in_ready) carries the relocation directory as 16-bit
// words; a word with first set restarts the parse at a new directory. Each
// accepted word produces exactly one result transaction on the output channel
// (out_valid/out_ready): a header acknowledgment, a skip, a fixup command
// (address, width, addend), an end marker, or an error status.
// Configuration: write image_delta and directory_bytes through cfg_write,
// cfg_index and cfg_data while no transaction is in flight.
// out_valid rises in the cycle after input acceptance. Throughput is one word
// per cycle while the receiver keeps up: the decode and the byte-count add sit
// between the parser state registers and the result register.
// in_ready is high whenever the result register is empty or being taken in
// the same cycle, so a stalled receiver holds the result and stops input
// after one pending result.
// Reset clears the parser to idle, the configuration registers to zero and
// drops out_valid; words are ignored until one arrives with first set.
module pe_base_relocation_engine_core
  import perbr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] word,
  input  logic        first,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [32:0] fixup_address,
  output logic [1:0]  fixup_width,
  output logic [63:0] addend,
  output logic        directory_done
);

  logic [63:0] image_delta;
  logic [31:0] directory_bytes;
  logic        in_accept;
  res_t        res_comb;
  res_t        res_reg;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_delta     <= '0;
      directory_bytes <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_IMAGE_DELTA: image_delta     <= cfg_data;
        CFG_DIR_BYTES:   directory_bytes <= cfg_data[31:0];
        default:         image_delta     <= image_delta;
      endcase
    end
  end

  // Input is taken whenever the result register can accept a new result.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  perbr_parse u_parse (
    .clk             (clk),
    .rst             (rst),
    .accept          (in_accept),
    .word            (word),
    .first           (first),
    .image_delta     (image_delta),
    .directory_bytes (directory_bytes),
    .res             (res_comb)
  );

  perbr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (in_accept),
    .res_in    (res_comb),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .res_out   (res_reg)
  );

  assign status         = res_reg.status;
  assign fixup_address  = res_reg.fixup_address;
  assign fixup_width    = res_reg.fixup_width;
  assign addend         = res_reg.addend;
  assign directory_done = res_reg.directory_done;

  // Every accepted word yields a pending result in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  // The directory only ends at a block boundary, never on an error or an ignored word.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && directory_done |->
      (status != ST_BAD_TYPE && status != ST_MALFORMED && status != ST_IGNORED))
    else $error("directory end reported with an error or ignored status");

  // Fixup payload fields are zero unless the result is a fixup.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_FIXUP |->
      (fixup_address == 33'd0 && fixup_width == FW_16 && addend == 64'd0))
    else $error("fixup fields set on a non-fixup result");

  // A result never appears in the cycle after reset.
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule
